>>> rtl/core/bitmap_image_rle_decoder_defines.svh
// Assertion macros used by the checker file of the RLE decoder.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef BITMAP_IMAGE_RLE_DECODER_DEFINES_SVH
`define BITMAP_IMAGE_RLE_DECODER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BIRLE_ASSERT_IMPL(name, cond, conseq) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error("birle check failed");

// The consequent must hold in the cycle after the antecedent.
`define BIRLE_ASSERT_NEXT(name, cond, conseq) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error("birle check failed");

`endif

>>> rtl/core/birle_pkg.sv
package birle_pkg;

  localparam int MaxPattern   = 16;
  localparam int MaxLineBytes = 512;
  localparam int MaxLines     = 4096;

  // A pattern unit never exceeds sixteen bytes, the most descriptors one byte may cause.
  localparam int PatCap  = (MaxPattern < 16) ? MaxPattern : 16;
  localparam int PatIdxW = (PatCap > 1) ? $clog2(PatCap) : 1;

  // The line counter must hold the last line plus the largest repeat.
  localparam int LineRawW = $clog2(MaxLines + 256);
  localparam int LineW    = (LineRawW > 13) ? LineRawW : 13;
  localparam int LbW      = $clog2(MaxLineBytes + 1);
  localparam int ColW     = 16;
  localparam int SpanW    = 13;
  localparam int FifoCntW = 2;

  localparam logic [1:0] REG_WIDTH_PIXELS   = 2'd0;
  localparam logic [1:0] REG_LINE_COUNT     = 2'd1;
  localparam logic [1:0] REG_PATTERN_LENGTH = 2'd2;

  typedef enum logic [2:0] {
    DESC_NONE,
    DESC_SOLID,
    DESC_LITERAL,
    DESC_PATTERN,
    DESC_NULL
  } desc_sel_t;

  typedef enum logic [1:0] {
    INC_NONE,
    INC_SOLID,
    INC_ONE,
    INC_SPAN
  } col_inc_t;

  typedef struct packed {
    desc_sel_t desc;
    col_inc_t  inc;
    logic      complete;
    logic      set_rep;
    logic      load_run;
    logic      load_lit;
    logic      store_pat;
    logic      dec_pend;
    logic      emit_step;
    logic      last;
  } cmd_t;

  typedef struct packed {
    logic active;
    logic byte_zero;
    logic byte_80;
    logic unit_zero;
    logic pend_one;
    logic emit_last;
    logic space;
  } status_t;

  typedef struct packed {
    logic [11:0] line_index;
    logic [7:0]  line_repeat;
    logic [9:0]  column;
    logic [4:0]  stride;
    logic [7:0]  write_count;
    logic [7:0]  data_byte;
    logic        last;
    logic        image_done;
  } desc_t;

endpackage

>>> rtl/core/birle_in_if.sv
interface birle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

>>> rtl/core/birle_out_if.sv
interface birle_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] line_index;
  logic [7:0]  line_repeat;
  logic [9:0]  column;
  logic [4:0]  stride;
  logic [7:0]  write_count;
  logic [7:0]  data_byte;
  logic        last;
  logic        image_done;

  modport source (
    output valid, output line_index, output line_repeat, output column, output stride,
    output write_count, output data_byte, output last, output image_done, input ready
  );
  modport sink (
    input valid, input line_index, input line_repeat, input column, input stride,
    input write_count, input data_byte, input last, input image_done, output ready
  );
endinterface

>>> rtl/core/bitmap_image_rle_decoder.sv
// Run-length bitmap body decoder. Body bytes enter on the body channel, one word per
// byte, and leave as write descriptors on the descriptor channel: solid runs, literal
// bytes and pattern runs each become descriptors, and vertical repeats set the line
// repeat of the next line. After the last byte of a pattern run the controller steps
// the pattern store (up to sixteen bytes) out into descriptors, one per pattern byte;
// the body channel is held off then. Descriptors wait in a two-word output queue, so
// the body channel keeps flowing while one word is still unread; body ready drops when
// the queue holds two words. Once the configured line count is reached the decoder
// takes and drops further bytes until reset. Write the configuration registers only
// between images or bytes while nothing is outstanding.
module bitmap_image_rle_decoder
  import birle_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [12:0]        cfg_data,
  birle_in_if.sink           body,
  birle_out_if.source        descriptor
);

  cmd_t    cmd;
  status_t status;
  desc_t   out_desc;

  birle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (body.valid),
    .in_ready (body.ready),
    .status   (status),
    .cmd      (cmd)
  );

  birle_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_byte   (body.in_byte),
    .cmd       (cmd),
    .status    (status),
    .out_valid (descriptor.valid),
    .out_ready (descriptor.ready),
    .out_desc  (out_desc)
  );

  assign descriptor.line_index  = out_desc.line_index;
  assign descriptor.line_repeat = out_desc.line_repeat;
  assign descriptor.column      = out_desc.column;
  assign descriptor.stride      = out_desc.stride;
  assign descriptor.write_count = out_desc.write_count;
  assign descriptor.data_byte   = out_desc.data_byte;
  assign descriptor.last        = out_desc.last;
  assign descriptor.image_done  = out_desc.image_done;

endmodule

>>> rtl/core/birle_dpath.sv
module birle_dpath
  import birle_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic [7:0]  in_byte,
  input  cmd_t        cmd,
  output status_t     status,
  output logic        out_valid,
  input  logic        out_ready,
  output desc_t       out_desc
);

  logic [12:0]        width_pixels;
  logic [12:0]        line_count;
  logic [4:0]         pattern_length;

  logic [7:0]         run_count;
  logic [SpanW-1:0]   span;
  logic [4:0]         unit;
  logic [7:0]         bytes_pending;
  logic [PatIdxW-1:0] wr_idx;
  logic [PatIdxW-1:0] emit_idx;
  logic [7:0]         pattern_store [PatCap];
  logic [ColW-1:0]    byte_column;
  logic [LineW-1:0]   current_line;
  logic [7:0]         vertical_repeat;
  logic               finished;

  desc_t              fifo_q [2];
  logic               wr_ptr;
  logic               rd_ptr;
  logic [FifoCntW-1:0] fifo_cnt;

  logic [4:0]         pat_eff;
  logic [13:0]        width_sum;
  logic [LbW-1:0]     lb_raw;
  logic [LbW-1:0]     line_bytes;
  logic [LineW-1:0]   eff_lines;
  logic [SpanW-1:0]   inc_val;
  logic [ColW:0]      col_sum;
  logic [ColW-1:0]    col_after;
  logic [7:0]         rep_eff;
  logic [LineW-1:0]   line_adv;
  logic               advance;
  logic               done;
  logic [ColW:0]      pat_col;
  desc_t              desc_new;
  logic               push;
  logic               pop;

  function automatic logic [9:0] sat_col(input logic [ColW:0] c);
    sat_col = (c > (ColW+1)'(1023)) ? 10'd1023 : c[9:0];
  endfunction

  assign pat_eff    = (pattern_length > 5'(PatCap)) ? 5'(PatCap) : pattern_length;
  assign width_sum  = {1'b0, width_pixels} + 14'd7;
  assign lb_raw     = LbW'(width_sum[13:3]);
  assign line_bytes = (width_sum[13:3] > 11'(MaxLineBytes)) ? LbW'(MaxLineBytes) : lb_raw;
  assign eff_lines  = (LineW'(line_count) > LineW'(MaxLines)) ? LineW'(MaxLines)
                                                               : LineW'(line_count);

  always_comb begin
    case (cmd.inc)
      INC_SOLID: inc_val = SpanW'(in_byte[6:0]);
      INC_ONE:   inc_val = SpanW'(1);
      INC_SPAN:  inc_val = span;
      default:   inc_val = '0;
    endcase
  end

  // The column saturates rather than wraps so that a long run past the line end stays past it.
  assign col_sum   = {1'b0, byte_column} + (ColW+1)'(inc_val);
  assign col_after = col_sum[ColW] ? {ColW{1'b1}} : col_sum[ColW-1:0];
  assign rep_eff   = cmd.set_rep ? in_byte : vertical_repeat;
  assign line_adv  = current_line + LineW'(rep_eff);
  assign advance   = cmd.complete && (col_after >= ColW'(line_bytes));
  assign done      = advance && (line_adv >= eff_lines);
  assign pat_col   = {1'b0, byte_column} + (ColW+1)'(emit_idx);

  always_comb begin
    desc_new.line_index  = current_line[11:0];
    desc_new.line_repeat = vertical_repeat;
    desc_new.column      = sat_col({1'b0, byte_column});
    desc_new.stride      = 5'd1;
    desc_new.write_count = 8'd1;
    desc_new.data_byte   = in_byte;
    desc_new.last        = cmd.last;
    desc_new.image_done  = done;
    push                 = 1'b0;
    case (cmd.desc)
      DESC_SOLID: begin
        desc_new.write_count = {1'b0, in_byte[6:0]};
        desc_new.data_byte   = in_byte[7] ? 8'hFF : 8'h00;
        push                 = 1'b1;
      end
      DESC_LITERAL: begin
        push = 1'b1;
      end
      DESC_PATTERN: begin
        desc_new.column      = sat_col(pat_col);
        desc_new.stride      = unit;
        desc_new.write_count = run_count;
        desc_new.data_byte   = pattern_store[emit_idx];
        push                 = 1'b1;
      end
      DESC_NULL: begin
        // Only an opcode that finishes the image without a write leaves a word.
        desc_new.line_index  = line_adv[11:0];
        desc_new.line_repeat = 8'd0;
        desc_new.column      = 10'd0;
        desc_new.data_byte   = 8'd0;
        desc_new.last        = 1'b1;
        push                 = done;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  assign pop       = out_valid && out_ready;
  assign out_valid = (fifo_cnt != '0);
  assign out_desc  = fifo_q[rd_ptr];

  assign status.active    = !finished && (current_line < eff_lines);
  assign status.byte_zero = (in_byte == 8'h00);
  assign status.byte_80   = (in_byte == 8'h80);
  assign status.unit_zero = (pat_eff == 5'd0);
  assign status.pend_one  = (bytes_pending == 8'd1);
  assign status.emit_last = (5'(emit_idx) == unit - 5'd1);
  assign status.space     = (fifo_cnt < FifoCntW'(2));

  always_ff @(posedge clk) begin
    if (rst) begin
      width_pixels    <= 13'd640;
      line_count      <= 13'd400;
      pattern_length  <= 5'd2;
      bytes_pending   <= '0;
      wr_idx          <= '0;
      emit_idx        <= '0;
      byte_column     <= '0;
      current_line    <= '0;
      vertical_repeat <= 8'd1;
      finished        <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_WIDTH_PIXELS:   width_pixels   <= cfg_data;
          REG_LINE_COUNT:     line_count     <= cfg_data;
          REG_PATTERN_LENGTH: pattern_length <= cfg_data[4:0];
          default:            ;
        endcase
      end
      if (cmd.load_run) begin
        bytes_pending <= {3'b000, pat_eff};
        wr_idx        <= '0;
        emit_idx      <= '0;
      end
      if (cmd.load_lit) begin
        bytes_pending <= in_byte;
      end
      if (cmd.store_pat) begin
        wr_idx <= wr_idx + PatIdxW'(1);
      end
      if (cmd.store_pat || cmd.dec_pend) begin
        bytes_pending <= bytes_pending - 8'd1;
      end
      if (cmd.emit_step) begin
        emit_idx <= emit_idx + PatIdxW'(1);
      end
      if (cmd.set_rep) begin
        vertical_repeat <= in_byte;
      end
      if (advance) begin
        byte_column     <= '0;
        current_line    <= line_adv;
        vertical_repeat <= 8'd1;
        if (line_adv >= eff_lines) begin
          finished <= 1'b1;
        end
      end else if (cmd.inc != INC_NONE) begin
        byte_column <= col_after;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_run) begin
      run_count <= in_byte;
      unit      <= pat_eff;
      span      <= SpanW'(in_byte) * SpanW'(pat_eff);
    end
    if (cmd.store_pat) begin
      pattern_store[wr_idx] <= in_byte;
    end
    if (push) begin
      fifo_q[wr_ptr] <= desc_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= 1'b0;
      rd_ptr   <= 1'b0;
      fifo_cnt <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   fifo_cnt <= fifo_cnt + FifoCntW'(1);
        2'b01:   fifo_cnt <= fifo_cnt - FifoCntW'(1);
        default: fifo_cnt <= fifo_cnt;
      endcase
    end
  end

endmodule

>>> rtl/core/birle_ctrl.sv
module birle_ctrl
  import birle_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_OPCODE,
    S_ZERO2,
    S_VSKIP,
    S_VCOUNT,
    S_PBYTES,
    S_LCOUNT,
    S_LBYTES,
    S_PEMIT
  } state_t;

  state_t state;
  state_t state_next;
  logic   take;

  assign in_ready = (state != S_PEMIT) && status.space;
  assign take     = in_valid && in_ready && status.active;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_OPCODE: begin
        if (take) begin
          if (status.byte_zero) begin
            state_next = S_ZERO2;
          end else if (status.byte_80) begin
            state_next = S_LCOUNT;
          end else begin
            cmd.desc     = DESC_SOLID;
            cmd.inc      = INC_SOLID;
            cmd.complete = 1'b1;
            cmd.last     = 1'b1;
          end
        end
      end
      S_ZERO2: begin
        if (take) begin
          if (status.byte_zero) begin
            state_next = S_VSKIP;
          end else if (status.unit_zero) begin
            cmd.desc     = DESC_NULL;
            cmd.complete = 1'b1;
            state_next   = S_OPCODE;
          end else begin
            cmd.load_run = 1'b1;
            state_next   = S_PBYTES;
          end
        end
      end
      S_VSKIP: begin
        if (take) begin
          state_next = S_VCOUNT;
        end
      end
      S_VCOUNT: begin
        if (take) begin
          cmd.set_rep  = 1'b1;
          cmd.desc     = DESC_NULL;
          cmd.complete = 1'b1;
          state_next   = S_OPCODE;
        end
      end
      S_PBYTES: begin
        if (take) begin
          cmd.store_pat = 1'b1;
          if (status.pend_one) begin
            state_next = S_PEMIT;
          end
        end
      end
      S_LCOUNT: begin
        if (take) begin
          if (status.byte_zero) begin
            cmd.desc     = DESC_NULL;
            cmd.complete = 1'b1;
            state_next   = S_OPCODE;
          end else begin
            cmd.load_lit = 1'b1;
            state_next   = S_LBYTES;
          end
        end
      end
      S_LBYTES: begin
        if (take) begin
          cmd.desc     = DESC_LITERAL;
          cmd.inc      = INC_ONE;
          cmd.dec_pend = 1'b1;
          cmd.last     = 1'b1;
          if (status.pend_one) begin
            cmd.complete = 1'b1;
            state_next   = S_OPCODE;
          end
        end
      end
      S_PEMIT: begin
        // One pattern word leaves per cycle while the output queue has space; the column moves only with the last one.
        if (status.space) begin
          cmd.desc      = DESC_PATTERN;
          cmd.emit_step = 1'b1;
          if (status.emit_last) begin
            cmd.inc      = INC_SPAN;
            cmd.complete = 1'b1;
            cmd.last     = 1'b1;
            state_next   = S_OPCODE;
          end
        end
      end
      default: begin
        state_next = S_OPCODE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_OPCODE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> rtl/core/birle_checker.sv
`include "bitmap_image_rle_decoder_defines.svh"

module birle_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [11:0] line_index,
  input logic [7:0]  line_repeat,
  input logic [9:0]  column,
  input logic [4:0]  stride,
  input logic [7:0]  write_count,
  input logic [7:0]  data_byte,
  input logic        last,
  input logic        image_done
);

  logic [52:0] word;

  assign word = {line_index, line_repeat, column, stride, write_count, data_byte,
                 last, image_done};

  // A word that waits must not change under the sink.
  `BIRLE_ASSERT_NEXT(a_word_held, out_valid && !out_ready, out_valid && $stable(word))

  // The word that ends the image is always the final word of its byte.
  `BIRLE_ASSERT_IMPL(a_done_is_last, out_valid && image_done, last)

  // Nothing follows the word that ends the image.
  `BIRLE_ASSERT_NEXT(a_done_final, out_valid && out_ready && image_done, !out_valid)

  // Stride is one for solid, literal and null words and the pattern length for pattern words, so it lies in 1 to 16.
  `BIRLE_ASSERT_IMPL(a_stride_range, out_valid, stride != 5'd0 && stride <= 5'd16)

endmodule

bind bitmap_image_rle_decoder birle_checker u_birle_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (descriptor.valid),
  .out_ready   (descriptor.ready),
  .line_index  (descriptor.line_index),
  .line_repeat (descriptor.line_repeat),
  .column      (descriptor.column),
  .stride      (descriptor.stride),
  .write_count (descriptor.write_count),
  .data_byte   (descriptor.data_byte),
  .last        (descriptor.last),
  .image_done  (descriptor.image_done)
);

>>> test/bitmap_image_rle_decoder_tb.sv
module bitmap_image_rle_decoder_tb;
  import birle_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] OP_ESC = 8'h00;
  localparam logic [7:0] OP_LIT = 8'h80;
  localparam int SETTLE_CYCLES = 24;
  localparam int STALL_LIMIT = 1000;

  typedef enum logic [2:0] {
    ST_OPCODE,
    ST_ZERO2,
    ST_VSKIP,
    ST_VCOUNT,
    ST_PBYTES,
    ST_LCOUNT,
    ST_LBYTES
  } parse_state_t;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [12:0] cfg_data;

  birle_in_if  body_ch ();
  birle_out_if desc_ch ();

  bitmap_image_rle_decoder dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .body       (body_ch),
    .descriptor (desc_ch)
  );

  // Decoder shadow state and register copies.
  logic [12:0]  px_width;
  logic [12:0]  line_limit;
  logic [4:0]   pat_len;
  parse_state_t pstate;
  logic [7:0]   pat_mem [PatCap];
  logic [7:0]   run_len;
  int unsigned  pend_cnt;
  int unsigned  col_pos;
  int unsigned  line_pos;
  logic [7:0]   vrep;
  bit           img_done;
  int unsigned  unit_bytes;

  desc_t      awaited_desc [$];
  logic [7:0] body_bytes [$];

  int  bytes_queued = 0;
  int  bytes_taken = 0;
  int  descs_seen = 0;
  int  reg_writes = 0;
  int  fail_count = 0;
  int  gap_pct = 0;
  int  src_gap = 0;
  int  sink_gap = 0;
  int  quiet_cycles = 0;
  int  est_line = 0;
  bit  byte_went = 0;

  initial begin
    clk = 1'b0;
  end

  always #6 clk = ~clk;

  function automatic int unsigned line_bytes();
    int unsigned b;
    b = (int'(px_width) + 7) >> 3;
    return (b > MaxLineBytes) ? MaxLineBytes : b;
  endfunction

  function automatic int unsigned lines_eff();
    int unsigned l;
    l = 32'(line_limit);
    return (l > MaxLines) ? MaxLines : l;
  endfunction

  function automatic int unsigned pat_eff();
    int unsigned p;
    p = 32'(pat_len);
    return (p > PatCap) ? PatCap : p;
  endfunction

  function automatic void advance_col(int unsigned k);
    col_pos = col_pos + k;
    if (col_pos > 32'hFFFF) col_pos = 32'hFFFF;
  endfunction

  function automatic desc_t make_desc(int unsigned c, int unsigned st, int unsigned cnt,
                                      logic [7:0] d, logic [7:0] rep);
    desc_t r;
    r.line_index  = line_pos[11:0];
    r.line_repeat = rep;
    r.column      = (c > 1023) ? 10'd1023 : c[9:0];
    r.stride      = st[4:0];
    r.write_count = cnt[7:0];
    r.data_byte   = d;
    r.last        = 1'b0;
    r.image_done  = 1'b0;
    return r;
  endfunction

  // Closes an opcode; the line moves on only once the column has reached the line width.
  function automatic bit end_opcode();
    pstate = ST_OPCODE;
    if (col_pos >= line_bytes()) begin
      col_pos  = 0;
      line_pos = line_pos + 32'(vrep);
      vrep     = 8'd1;
      if (line_pos >= lines_eff()) begin
        img_done = 1'b1;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  task automatic decode_body_byte(input logic [7:0] b);
    desc_t outs [$];
    bit    fin;
    fin = 1'b0;
    if (img_done || line_pos >= lines_eff()) return;
    case (pstate)
      ST_OPCODE: begin
        if (b == OP_ESC) pstate = ST_ZERO2;
        else if (b == OP_LIT) pstate = ST_LCOUNT;
        else begin
          outs.push_back(make_desc(col_pos, 1, 32'(b[6:0]), b[7] ? 8'hFF : 8'h00, vrep));
          advance_col(32'(b[6:0]));
          fin = end_opcode();
        end
      end
      ST_ZERO2: begin
        if (b == OP_ESC) pstate = ST_VSKIP;
        else begin
          run_len    = b;
          unit_bytes = pat_eff();
          if (unit_bytes == 0) fin = end_opcode();
          else begin
            pend_cnt = unit_bytes;
            pstate   = ST_PBYTES;
          end
        end
      end
      ST_VSKIP: pstate = ST_VCOUNT;
      ST_VCOUNT: begin
        vrep = b;
        fin  = end_opcode();
      end
      ST_PBYTES: begin
        pat_mem[PatIdxW'(unit_bytes - pend_cnt)] = b;
        pend_cnt--;
        if (pend_cnt == 0) begin
          for (int i = 0; i < unit_bytes; i++)
            outs.push_back(make_desc(col_pos + 32'(i), unit_bytes, 32'(run_len),
                                     pat_mem[PatIdxW'(i)], vrep));
          advance_col(32'(run_len) * unit_bytes);
          fin = end_opcode();
        end
      end
      ST_LCOUNT: begin
        if (b == 8'd0) fin = end_opcode();
        else begin
          pend_cnt = 32'(b);
          pstate   = ST_LBYTES;
        end
      end
      ST_LBYTES: begin
        outs.push_back(make_desc(col_pos, 1, 1, b, vrep));
        advance_col(1);
        pend_cnt--;
        if (pend_cnt == 0) fin = end_opcode();
      end
      default: pstate = ST_OPCODE;
    endcase
    // An opcode that finishes the image without writing still reports it.
    if (fin && outs.size() == 0) outs.push_back(make_desc(col_pos, 1, 1, 8'h00, 8'h00));
    if (outs.size() > 0) begin
      outs[outs.size() - 1].last       = 1'b1;
      outs[outs.size() - 1].image_done = fin;
    end
    foreach (outs[i]) awaited_desc.push_back(outs[i]);
  endtask

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : monitor
    desc_t want;
    if (rst) begin
      px_width   = 13'd640;
      line_limit = 13'd400;
      pat_len    = 5'd2;
      pstate     = ST_OPCODE;
      foreach (pat_mem[i]) pat_mem[i] = 8'h00;
      run_len    = 8'd0;
      pend_cnt   = 0;
      col_pos    = 0;
      line_pos   = 0;
      vrep       = 8'd1;
      img_done   = 1'b0;
      unit_bytes = 0;
      byte_went  = 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_WIDTH_PIXELS:   px_width = cfg_data;
          REG_LINE_COUNT:     line_limit = cfg_data;
          REG_PATTERN_LENGTH: pat_len = cfg_data[4:0];
          default: ;
        endcase
      end
      byte_went = body_ch.valid && body_ch.ready;
      if (byte_went) begin
        decode_body_byte(body_ch.in_byte);
        bytes_taken++;
      end
      if (desc_ch.valid && desc_ch.ready) begin
        if (awaited_desc.size() == 0) begin
          $error("descriptor at line %0d column %0d arrived with none outstanding",
                 desc_ch.line_index, desc_ch.column);
          fail_count++;
        end else begin
          want = awaited_desc.pop_front();
          check_field("line_index", 16'(want.line_index), 16'(desc_ch.line_index));
          check_field("line_repeat", 16'(want.line_repeat), 16'(desc_ch.line_repeat));
          check_field("column", 16'(want.column), 16'(desc_ch.column));
          check_field("stride", 16'(want.stride), 16'(desc_ch.stride));
          check_field("write_count", 16'(want.write_count), 16'(desc_ch.write_count));
          check_field("data_byte", 16'(want.data_byte), 16'(desc_ch.data_byte));
          check_field("last", 16'(want.last), 16'(desc_ch.last));
          check_field("image_done", 16'(want.image_done), 16'(desc_ch.image_done));
          descs_seen++;
        end
      end
    end
  end

  // Body word source: valid holds until the word is taken, gaps fall only between words.
  always @(negedge clk) begin
    if (rst) body_ch.valid <= 1'b0;
    else if (!body_ch.valid || byte_went) begin
      if (src_gap > 0) begin
        src_gap--;
        body_ch.valid <= 1'b0;
      end else if (body_bytes.size() == 0) begin
        body_ch.valid <= 1'b0;
      end else if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
        src_gap = $urandom_range(0, 6);
        body_ch.valid <= 1'b0;
      end else begin
        body_ch.valid   <= 1'b1;
        body_ch.in_byte <= body_bytes.pop_front();
      end
    end
  end

  always @(negedge clk) begin
    if (rst) desc_ch.ready <= 1'b0;
    else if (sink_gap > 0) begin
      sink_gap--;
      desc_ch.ready <= 1'b0;
    end else if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      sink_gap = $urandom_range(0, 6);
      desc_ch.ready <= 1'b0;
    end else begin
      desc_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_write || (body_ch.valid && body_ch.ready) ||
        (desc_ch.valid && desc_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    reg_writes++;
  endtask

  task automatic put(input logic [7:0] b);
    body_bytes.push_back(b);
    bytes_queued++;
  endtask

  task automatic put_pattern(input logic [7:0] nn);
    put(OP_ESC);
    put(nn);
    repeat (pat_eff()) put(8'($urandom));
    est_line++;
  endtask

  task automatic put_literal(input logic [7:0] nn);
    put(OP_LIT);
    put(nn);
    repeat (nn) put(8'($urandom));
    est_line++;
  endtask

  // Waits until every word is taken and answered, then lets the pattern emitter
  // run dry. Trailing bytes close any opcode left open so registers change cleanly.
  task automatic settle();
    forever begin
      @(negedge clk);
      while (bytes_taken != bytes_queued || awaited_desc.size() != 0) @(negedge clk);
      repeat (SETTLE_CYCLES) @(negedge clk);
      if (pstate == ST_OPCODE || img_done || line_pos >= lines_eff()) break;
      put(8'($urandom));
    end
  endtask

  task automatic random_words(input int target);
    int         first;
    int         pick;
    logic [7:0] nn;
    first = bytes_queued;
    while (bytes_queued - first < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        nn = 8'($urandom_range(1, 255));
        if (nn == OP_LIT) nn = OP_LIT + 8'd1;
        put(nn);
        est_line++;
      end else if (pick < 55) begin
        put_pattern(8'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 255)
                                                   : $urandom_range(1, 8)));
      end else if (pick < 75) begin
        put_literal(8'($urandom_range(0, 10)));
      end else if (pick < 87) begin
        // Large repeats only while the line budget is far from the limit.
        nn = 8'((est_line < 2500 && $urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                               : $urandom_range(0, 3));
        put(OP_ESC);
        put(OP_ESC);
        put(8'($urandom));
        put(nn);
        est_line += int'(nn);
      end else begin
        repeat ($urandom_range(1, 3)) put(8'($urandom));
        est_line += 2;
      end
    end
  endtask

  task automatic run_phase(input logic [12:0] w, input logic [12:0] l, input logic [4:0] p,
                           input int n, input int odds);
    write_reg(REG_WIDTH_PIXELS, w);
    write_reg(REG_LINE_COUNT, l);
    write_reg(REG_PATTERN_LENGTH, p);
    est_line = int'(line_pos);
    gap_pct  = odds;
    random_words(n);
  endtask

  initial begin
    logic [7:0] directed [] = '{
      8'h01, 8'h7F, 8'h81, 8'hFF,
      OP_ESC, 8'h03, 8'hAA, 8'h55,
      OP_LIT, 8'h02, 8'h00, 8'hFF,
      OP_LIT, 8'h00,
      OP_ESC, OP_ESC, 8'h5A, 8'h00,
      8'h85,
      OP_ESC, OP_ESC, 8'hFF, 8'hFF,
      8'hFF
    };
    rst           = 1'b1;
    cfg_write     = 1'b0;
    cfg_index     = REG_WIDTH_PIXELS;
    cfg_data      = 13'd0;
    body_ch.valid   = 1'b0;
    body_ch.in_byte = 8'h00;
    desc_ch.ready   = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: both fills, count extremes, empty literal, repeats of 0 and 255.
    gap_pct = 25;
    foreach (directed[i]) put(directed[i]);
    settle();

    run_phase(13'd1, 13'd4096, 5'd1, 30, 20);
    settle();
    run_phase(13'd4096, 13'd8191, 5'd16, 30, 15);
    put_literal(8'd130);
    settle();
    run_phase(13'd0, 13'd4096, 5'd0, 20, 30);
    settle();
    run_phase(13'd8191, 13'd4096, 5'd31, 20, 10);
    settle();

    // With the line limit below the current line every word is dropped.
    write_reg(REG_LINE_COUNT, 13'd1);
    repeat (6) put(8'($urandom));
    settle();

    run_phase(13'd640, 13'd4096, 5'd2, 30, 25);
    settle();
    run_phase(13'd17, 13'd4096, 5'd5, 30, 0);
    settle();

    // Finish the image on a vertical repeat, then feed words that must be dropped.
    write_reg(REG_WIDTH_PIXELS, 13'd0);
    write_reg(REG_LINE_COUNT, 13'(line_pos + 2));
    write_reg(REG_PATTERN_LENGTH, 5'd3);
    put(8'h83);
    put(OP_ESC);
    put(OP_ESC);
    put(8'hAA);
    put(8'h04);
    repeat (4) put(8'($urandom));
    settle();
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Run covered %0d body words, %0d descriptors and %0d register writes.",
             bytes_taken, descs_seen, reg_writes);
    $display("Image end %0s at line %0d.", img_done ? "reached" : "not reached", line_pos);
    if (fail_count == 0 && awaited_desc.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
